### rtl/tbeq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the three-band stereo equaliser.
// Used by tbeq_lane, tbeq_merge and three_band_stereo_equalizer; no dependencies.

package tbeq_pkg;

    // Sample format and internal headroom
    localparam int SAMPLE_BITS  = 24;
    localparam int ROUND_BITS   = 8;
    localparam int INNER_BITS   = SAMPLE_BITS + ROUND_BITS;
    localparam int FRAC_BITS    = 16;

    // Configuration register map
    localparam int NUM_REGS     = 7;
    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_LOW_COEF       = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_LOW_HALF_GAIN  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_HIGH_COEF      = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_HIGH_HALF_GAIN = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_MID_COEF       = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_MID_CENTER     = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_MID_HALF_GAIN  = 3'd6;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_result;
        logic signed [SAMPLE_BITS-1:0] right_result;
        logic                          clipped;
    } out_beat_t;

    // Lane status towards the merge stage
    typedef struct packed {
        logic idle;
        logic done;
    } lane_stat_t;

endpackage

### rtl/tbeq_lane.sv
`timescale 1ns / 1ps
// One channel of the equaliser: low shelf, high shelf, peak, sequenced
// over a single shared multiplier. Depends on tbeq_pkg.

module tbeq_lane #(
    parameter int COEF_BITS = 20
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic signed [tbeq_pkg::SAMPLE_BITS-1:0]           sample,
    input  logic [tbeq_pkg::NUM_REGS-1:0][COEF_BITS-1:0]      coef,
    input  logic                                              take,
    output tbeq_pkg::lane_stat_t                              stat,
    output logic signed [tbeq_pkg::INNER_BITS-1:0]            value
);
    import tbeq_pkg::*;

    localparam int W  = INNER_BITS;
    localparam int AW = W + 1;
    localparam int KW = COEF_BITS + 2;
    localparam int PW = AW + KW;
    localparam int UNITY = 1 << FRAC_BITS;
    localparam int STEP_BITS = 5;

    localparam logic signed [PW-1:0] W_MAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] W_MIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [PW-1:0] ROUND_HALF =
        {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    // Sequencer steps
    localparam logic [STEP_BITS-1:0] L_MUL_S  = 5'd0;
    localparam logic [STEP_BITS-1:0] L_U      = 5'd1;
    localparam logic [STEP_BITS-1:0] L_MUL_U  = 5'd2;
    localparam logic [STEP_BITS-1:0] L_AP     = 5'd3;
    localparam logic [STEP_BITS-1:0] L_OP     = 5'd4;
    localparam logic [STEP_BITS-1:0] L_MUL_H  = 5'd5;
    localparam logic [STEP_BITS-1:0] L_OUT    = 5'd6;
    localparam logic [STEP_BITS-1:0] H_MUL_S  = 5'd7;
    localparam logic [STEP_BITS-1:0] H_U      = 5'd8;
    localparam logic [STEP_BITS-1:0] H_MUL_U  = 5'd9;
    localparam logic [STEP_BITS-1:0] H_AP     = 5'd10;
    localparam logic [STEP_BITS-1:0] H_OP     = 5'd11;
    localparam logic [STEP_BITS-1:0] H_MUL_H  = 5'd12;
    localparam logic [STEP_BITS-1:0] H_OUT    = 5'd13;
    localparam logic [STEP_BITS-1:0] P_K      = 5'd14;
    localparam logic [STEP_BITS-1:0] P_MUL_S1 = 5'd15;
    localparam logic [STEP_BITS-1:0] P_MUL_D  = 5'd16;
    localparam logic [STEP_BITS-1:0] P_MUL_S2 = 5'd17;
    localparam logic [STEP_BITS-1:0] P_XM     = 5'd18;
    localparam logic [STEP_BITS-1:0] P_U      = 5'd19;
    localparam logic [STEP_BITS-1:0] P_MUL_U  = 5'd20;
    localparam logic [STEP_BITS-1:0] P_MS     = 5'd21;
    localparam logic [STEP_BITS-1:0] P_AP     = 5'd22;
    localparam logic [STEP_BITS-1:0] P_OP     = 5'd23;
    localparam logic [STEP_BITS-1:0] P_MUL_H  = 5'd24;
    localparam logic [STEP_BITS-1:0] P_OUT    = 5'd25;

    typedef enum logic [2:0] {
        LANE_IDLE = 3'b001,
        LANE_RUN  = 3'b010,
        LANE_DONE = 3'b100
    } lane_state_t;

    function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] v);
        logic signed [W-1:0] r;
        if (v > W_MAX)
            r = W_MAX[W-1:0];
        else if (v < W_MIN)
            r = W_MIN[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    function automatic logic signed [PW-1:0] sxw(input logic signed [W-1:0] v);
        return {{(PW-W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [PW-1:0] sxa(input logic signed [AW-1:0] v);
        return {{(PW-AW){v[AW-1]}}, v};
    endfunction

    function automatic logic signed [AW-1:0] ext_a(input logic signed [W-1:0] v);
        return {v[W-1], v};
    endfunction

    function automatic logic signed [KW-1:0] ext_k(input logic [COEF_BITS-1:0] v);
        return {{2{v[COEF_BITS-1]}}, v};
    endfunction

    lane_state_t              state_reg, state_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic signed [W-1:0]      x_reg, x_next;
    logic signed [W-1:0]      u_reg, u_next;
    logic signed [W-1:0]      ap_reg, ap_next;
    logic signed [W-1:0]      t_reg, t_next;
    logic signed [W-1:0]      m_reg, m_next;
    logic signed [AW-1:0]     op_reg, op_next;
    logic signed [KW-1:0]     k_reg, k_next;
    logic signed [W-1:0]      low_s_reg, low_s_next;
    logic signed [W-1:0]      high_s_reg, high_s_next;
    logic signed [W-1:0]      p1_reg, p1_next;
    logic signed [W-1:0]      p2_reg, p2_next;

    logic signed [KW-1:0]     lc, lh, hc, hh, mc, md, mh;
    logic signed [AW-1:0]     mul_a;
    logic signed [KW-1:0]     mul_k;
    logic signed [PW-1:0]     prod;
    logic signed [PW-1:0]     rnd;
    logic signed [W-1:0]      mul_res;

    assign lc = ext_k(coef[REG_LOW_COEF]);
    assign lh = ext_k(coef[REG_LOW_HALF_GAIN]);
    assign hc = ext_k(coef[REG_HIGH_COEF]);
    assign hh = ext_k(coef[REG_HIGH_HALF_GAIN]);
    assign mc = ext_k(coef[REG_MID_COEF]);
    assign md = ext_k(coef[REG_MID_CENTER]);
    assign mh = ext_k(coef[REG_MID_HALF_GAIN]);

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_k = '0;
        case (step_reg)
            L_MUL_S:  begin mul_a = ext_a(low_s_reg);  mul_k = lc;    end
            L_MUL_U:  begin mul_a = ext_a(u_reg);      mul_k = lc;    end
            L_MUL_H:  begin mul_a = op_reg;            mul_k = lh;    end
            H_MUL_S:  begin mul_a = ext_a(high_s_reg); mul_k = hc;    end
            H_MUL_U:  begin mul_a = ext_a(u_reg);      mul_k = hc;    end
            H_MUL_H:  begin mul_a = op_reg;            mul_k = hh;    end
            P_MUL_S1: begin mul_a = ext_a(p1_reg);     mul_k = k_reg; end
            P_MUL_D:  begin mul_a = ext_a(t_reg);      mul_k = md;    end
            P_MUL_S2: begin mul_a = ext_a(p2_reg);     mul_k = mc;    end
            P_MUL_U:  begin mul_a = ext_a(u_reg);      mul_k = mc;    end
            P_MUL_H:  begin mul_a = op_reg;            mul_k = mh;    end
            default:  ;
        endcase
    end

    // Q3.16 product, round half up, saturate
    assign prod    = mul_a * mul_k;
    assign rnd     = (prod + ROUND_HALF) >>> FRAC_BITS;
    assign mul_res = sat_w(rnd);

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        x_next      = x_reg;
        u_next      = u_reg;
        ap_next     = ap_reg;
        t_next      = t_reg;
        m_next      = m_reg;
        op_next     = op_reg;
        k_next      = k_reg;
        low_s_next  = low_s_reg;
        high_s_next = high_s_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        case (state_reg)
            LANE_IDLE:
            begin
                if (start)
                begin
                    x_next     = {sample, {ROUND_BITS{1'b0}}};
                    step_next  = '0;
                    state_next = LANE_RUN;
                end
            end
            LANE_RUN:
            begin
                step_next = step_reg + STEP_BITS'(1);
                case (step_reg)
                    L_MUL_S, L_MUL_U, L_MUL_H, H_MUL_S, H_MUL_U, H_MUL_H,
                    P_MUL_S1, P_MUL_S2, P_MUL_U, P_MUL_H:
                        t_next = mul_res;
                    L_U, H_U:
                        u_next = sat_w(sxw(x_reg) - sxw(t_reg));
                    L_AP:
                    begin
                        ap_next    = sat_w(sxw(t_reg) + sxw(low_s_reg));
                        low_s_next = u_reg;
                    end
                    H_AP:
                    begin
                        ap_next     = sat_w(sxw(t_reg) + sxw(high_s_reg));
                        high_s_next = u_reg;
                    end
                    L_OP:
                        op_next = ext_a(x_reg) + ext_a(ap_reg);
                    H_OP, P_OP:
                        op_next = ext_a(x_reg) - ext_a(ap_reg);
                    L_OUT, H_OUT:
                        x_next = sat_w(sxw(x_reg) + sxw(t_reg));
                    P_K:
                        k_next = KW'(UNITY) - mc;
                    P_MUL_D:
                        m_next = mul_res;
                    P_XM:
                        op_next = ext_a(x_reg) - ext_a(m_reg);
                    P_U:
                        u_next = sat_w(sxa(op_reg) + sxw(t_reg));
                    P_MS:
                        op_next = ext_a(m_reg) + ext_a(p2_reg);
                    P_AP:
                    begin
                        // delay line shifts before the new value goes in
                        ap_next = sat_w(sxa(op_reg) - sxw(t_reg));
                        p2_next = p1_reg;
                        p1_next = u_reg;
                    end
                    P_OUT:
                    begin
                        x_next     = sat_w(sxw(x_reg) + sxw(t_reg));
                        state_next = LANE_DONE;
                    end
                    default: ;
                endcase
            end
            LANE_DONE:
            begin
                if (take)
                    state_next = LANE_IDLE;
            end
            default:
                state_next = LANE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= LANE_IDLE;
            step_reg   <= '0;
            low_s_reg  <= '0;
            high_s_reg <= '0;
            p1_reg     <= '0;
            p2_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            low_s_reg  <= low_s_next;
            high_s_reg <= high_s_next;
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        u_reg  <= u_next;
        ap_reg <= ap_next;
        t_reg  <= t_next;
        m_reg  <= m_next;
        op_reg <= op_next;
        k_reg  <= k_next;
    end

    assign stat.idle = (state_reg == LANE_IDLE);
    assign stat.done = (state_reg == LANE_DONE);
    assign value     = x_reg;

endmodule

### rtl/tbeq_merge.sv
`timescale 1ns / 1ps
// Merge stage: rounds both lane results to sample width, saturates, ORs the
// clip flags and holds the output beat. Depends on tbeq_pkg.

module tbeq_merge (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  tbeq_pkg::lane_stat_t                    left_stat,
    input  tbeq_pkg::lane_stat_t                    right_stat,
    input  logic signed [tbeq_pkg::INNER_BITS-1:0]  left_value,
    input  logic signed [tbeq_pkg::INNER_BITS-1:0]  right_value,
    input  logic                                    out_stall,
    output logic                                    take,
    output logic                                    out_valid,
    output tbeq_pkg::out_beat_t                     out_data
);
    import tbeq_pkg::*;

    localparam int W = INNER_BITS;
    localparam int S = SAMPLE_BITS;
    localparam logic signed [W:0] HALF_LSB =
        {{(W+1-ROUND_BITS){1'b0}}, 1'b1, {(ROUND_BITS-1){1'b0}}};

    // returns {clip, result}
    function automatic logic [S:0] round_sat(input logic signed [W-1:0] v);
        logic signed [W:0] sum;
        logic        [S:0] q;
        logic              clip;
        sum  = {v[W-1], v} + HALF_LSB;
        q    = sum[W:ROUND_BITS];
        clip = q[S] ^ q[S-1];
        if (clip)
            return {1'b1, q[S], {(S-1){~q[S]}}};
        return {1'b0, q[S-1:0]};
    endfunction

    logic [S:0]  left_rs, right_rs;
    logic        valid_reg, valid_next;
    out_beat_t   data_reg, data_next;

    assign left_rs  = round_sat(left_value);
    assign right_rs = round_sat(right_value);
    assign take     = left_stat.done && right_stat.done && (!valid_reg || !out_stall);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (take)
        begin
            valid_next             = 1'b1;
            data_next.left_result  = left_rs[S-1:0];
            data_next.right_result = right_rs[S-1:0];
            data_next.clipped      = left_rs[S] | right_rs[S];
        end
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/three_band_stereo_equalizer.sv
`timescale 1ns / 1ps
// Top level of the three-band stereo equaliser: configuration registers,
// two channel lanes and the merge stage. Depends on tbeq_pkg, tbeq_lane, tbeq_merge.
//
//  port group | dir | beat / meaning
//  -----------+-----+--------------------------------------------------
//  in_*       | in  | in_data: left_sample, right_sample (signed)
//  out_*      | out | out_data: left_result, right_result, clipped
//  cfg_*      | in  | cfg_index selects one of seven Q3.16 registers
//
// Sequencing: each lane runs a 26-step sequence through its one shared
// multiplier, then waits in the done state to hand over its result and
// returns to idle; a new pair is only taken once both lanes are idle, so
// the block never takes a pair before it is through with the last one.
// Reset clears the delay state of both channels and all configuration registers to zero.
// The output register holds a result under out_stall while the lanes run on;
// a finished lane waits until the output register can take its result.

module three_band_stereo_equalizer #(
    parameter int COEF_BITS = 20
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  tbeq_pkg::in_beat_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output tbeq_pkg::out_beat_t                    out_data,
    input  logic                                   cfg_write,
    input  logic [tbeq_pkg::REG_IDX_BITS-1:0]      cfg_index,
    input  logic [COEF_BITS-1:0]                   cfg_data
);
    import tbeq_pkg::*;

    // Coefficient bank shared by both lanes
    logic [NUM_REGS-1:0][COEF_BITS-1:0] coef_reg;

    lane_stat_t                   left_stat, right_stat;
    logic signed [INNER_BITS-1:0] left_value, right_value;
    logic                         start;
    logic                         take;

    // Writes beyond the register map are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= '0;
        else if (cfg_write && (cfg_index < REG_IDX_BITS'(NUM_REGS)))
            coef_reg[cfg_index] <= cfg_data;
    end

    // Both lanes start together and run in lockstep
    assign in_stall = !(left_stat.idle && right_stat.idle);
    assign start    = in_valid && !in_stall;

    tbeq_lane #(
        .COEF_BITS (COEF_BITS)
    ) u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sample (in_data.left_sample),
        .coef   (coef_reg),
        .take   (take),
        .stat   (left_stat),
        .value  (left_value)
    );

    tbeq_lane #(
        .COEF_BITS (COEF_BITS)
    ) u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sample (in_data.right_sample),
        .coef   (coef_reg),
        .take   (take),
        .stat   (right_stat),
        .value  (right_value)
    );

    // Final rounding, saturation and output beat register
    tbeq_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .left_stat   (left_stat),
        .right_stat  (right_stat),
        .left_value  (left_value),
        .right_value (right_value),
        .out_stall   (out_stall),
        .take        (take),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

    // Lanes never drift apart
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        left_stat == right_stat)
        else $error("channel lanes out of step");

    // An accepted beat keeps the input side stalled next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> in_stall)
        else $error("input not stalled after accepting a beat");

    // A handover always shows up on the output
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid)
        else $error("handover without output beat");

    // A finished lane holds its result until handed over
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (left_stat.done && !take) |=> left_stat.done)
        else $error("lane result dropped before handover");

endmodule

### sim/three_band_stereo_equalizer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for three_band_stereo_equalizer: directed and random stereo beats,
// checked against a fixed-point model of the three cascaded stages held here.
// Depends on tbeq_pkg and the three_band_stereo_equalizer RTL.

module three_band_stereo_equalizer_test;

    import tbeq_pkg::*;

    localparam int COEF_BITS = 20;

    // Index 7 is outside the register map; writes to it must be dropped
    localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    localparam longint INNER_MAX  = (longint'(1) <<< (INNER_BITS - 1)) - 1;
    localparam longint INNER_MIN  = -INNER_MAX - 1;
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint UNITY      = longint'(1) <<< FRAC_BITS;
    localparam int     COEF_MAX   = (1 << (COEF_BITS - 1)) - 1;
    localparam int     COEF_MIN   = -(1 << (COEF_BITS - 1));

    // The tail wait is a good margin on top of one pass of a pair through the lanes
    localparam int TAIL_CYCLES = 80;

    typedef enum int {BANK_MILD, BANK_STRONG, BANK_WIDE} bank_kind_t;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    in_beat_t                in_data   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    out_beat_t               out_data;
    logic                    cfg_write = 1'b0;
    logic [REG_IDX_BITS-1:0] cfg_index = '0;
    logic [COEF_BITS-1:0]    cfg_data  = '0;

    // Model state: register copies and per-channel delays (0 left, 1 right)
    longint coef_bank [NUM_REGS];
    longint low_state [2];
    longint high_state[2];
    longint peak_one  [2];
    longint peak_two  [2];

    out_beat_t pending_results[$];
    int        errors    = 0;
    int        reported  = 0;
    bit        steady    = 1'b0;   // when set, neither side idles

    three_band_stereo_equalizer #(
        .COEF_BITS (COEF_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point model
    // ------------------------------------------------------------------

    function automatic longint clamp_inner(input longint v);
        if (v > INNER_MAX)
            return INNER_MAX;
        if (v < INNER_MIN)
            return INNER_MIN;
        return v;
    endfunction

    // Signal times Q3.16 value, round half up, then clamp to the inner width
    function automatic longint qmul(input longint a, input longint k);
        return clamp_inner((a * k + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    function automatic longint shelf_stage(input longint x, input longint c, input longint h,
                                           input bit low_band, inout longint st);
        longint u;
        longint ap;
        u  = clamp_inner(x - qmul(st, c));
        ap = clamp_inner(qmul(u, c) + st);
        st = u;
        if (low_band)
            return clamp_inner(x + qmul(x + ap, h));
        return clamp_inner(x + qmul(x - ap, h));
    endfunction

    function automatic longint peak_stage(input longint x, input int ch);
        longint c;
        longint d;
        longint h;
        longint s1;
        longint s2;
        longint m;
        longint u;
        longint ap;
        c  = coef_bank[REG_MID_COEF];
        d  = coef_bank[REG_MID_CENTER];
        h  = coef_bank[REG_MID_HALF_GAIN];
        s1 = peak_one[ch];
        s2 = peak_two[ch];
        m  = qmul(qmul(s1, UNITY - c), d);
        u  = clamp_inner(x - m + qmul(s2, c));
        ap = clamp_inner(-qmul(u, c) + m + s2);
        // delay line shifts before the new value goes in
        peak_two[ch] = s1;
        peak_one[ch] = u;
        return clamp_inner(x + qmul(x - ap, h));
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] equalize_channel(
        input logic signed [SAMPLE_BITS-1:0] sample, input int ch, inout bit clip);
        longint v;
        v = longint'(sample) <<< ROUND_BITS;
        v = shelf_stage(v, coef_bank[REG_LOW_COEF], coef_bank[REG_LOW_HALF_GAIN], 1'b1,
                        low_state[ch]);
        v = shelf_stage(v, coef_bank[REG_HIGH_COEF], coef_bank[REG_HIGH_HALF_GAIN], 1'b0,
                        high_state[ch]);
        v = peak_stage(v, ch);
        // only this final saturation raises the clip flag
        v = (v + (longint'(1) <<< (ROUND_BITS - 1))) >>> ROUND_BITS;
        if (v > SAMPLE_MAX)
        begin
            v    = SAMPLE_MAX;
            clip = 1'b1;
        end
        else if (v < SAMPLE_MIN)
        begin
            v    = SAMPLE_MIN;
            clip = 1'b1;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic out_beat_t equalize_pair(input in_beat_t beat);
        out_beat_t res;
        bit        clip;
        clip             = 1'b0;
        res.left_result  = equalize_channel($signed(beat.left_sample), 0, clip);
        res.right_result = equalize_channel($signed(beat.right_sample), 1, clip);
        res.clipped      = clip;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        int                            pick;
        logic signed [SAMPLE_BITS-1:0] raw;
        pick = $urandom_range(0, 9);
        raw  = SAMPLE_BITS'($urandom);
        if (pick < 4)
            return raw;
        if (pick < 9)
            return raw >>> $urandom_range(1, 16);
        case ($urandom_range(0, 3))
            0:       return SAMPLE_BITS'(SAMPLE_MAX);
            1:       return SAMPLE_BITS'(SAMPLE_MIN);
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic int spread(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // One beat into the block; the expectation is pushed at the accepting edge
    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] left,
                             input logic signed [SAMPLE_BITS-1:0] right);
        in_beat_t beat;
        int       gap;
        beat.left_sample  = left;
        beat.right_sample = right;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(equalize_pair(beat));
    endtask

    // Stop sending and let every outstanding result drain out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= COEF_BITS'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx < NUM_REGS)
            coef_bank[idx] = longint'($signed(COEF_BITS'(value)));
        @(posedge clk);
    endtask

    task automatic write_all(input int value);
        write_reg(REG_LOW_COEF,       value);
        write_reg(REG_LOW_HALF_GAIN,  value);
        write_reg(REG_HIGH_COEF,      value);
        write_reg(REG_HIGH_HALF_GAIN, value);
        write_reg(REG_MID_COEF,       value);
        write_reg(REG_MID_CENTER,     value);
        write_reg(REG_MID_HALF_GAIN,  value);
    endtask

    // Mild banks keep the allpasses stable (|c| < 1) so the delays carry real
    // history; strong ones push the gains; wide ones use any bit pattern
    task automatic program_bank(input bank_kind_t kind);
        if (kind == BANK_WIDE)
        begin
            write_reg(REG_LOW_COEF,       int'($urandom));
            write_reg(REG_LOW_HALF_GAIN,  int'($urandom));
            write_reg(REG_HIGH_COEF,      int'($urandom));
            write_reg(REG_HIGH_HALF_GAIN, int'($urandom));
            write_reg(REG_MID_COEF,       int'($urandom));
            write_reg(REG_MID_CENTER,     int'($urandom));
            write_reg(REG_MID_HALF_GAIN,  int'($urandom));
        end
        else
        begin
            write_reg(REG_LOW_COEF,       spread(60000));
            write_reg(REG_HIGH_COEF,      spread(60000));
            write_reg(REG_MID_COEF,       spread(60000));
            write_reg(REG_MID_CENTER,     spread(65536));
            if (kind == BANK_MILD)
            begin
                write_reg(REG_LOW_HALF_GAIN,  spread(40000));
                write_reg(REG_HIGH_HALF_GAIN, spread(40000));
                write_reg(REG_MID_HALF_GAIN,  spread(40000));
            end
            else
            begin
                write_reg(REG_LOW_HALF_GAIN,  spread(400000));
                write_reg(REG_HIGH_HALF_GAIN, spread(400000));
                write_reg(REG_MID_HALF_GAIN,  spread(400000));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset are all zero, i.e. flat: samples come straight through
    task automatic test_flat_after_reset();
        send_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MIN));
        send_pair(SAMPLE_BITS'(SAMPLE_MIN), SAMPLE_BITS'(SAMPLE_MAX));
        send_pair('0, '1);
        send_pair('1, '0);
        send_pair(24'h555555, 24'hAAAAAA);
        send_pair(24'hAAAAAA, 24'h555555);
        wait_idle();
    endtask

    // Every register at its top and bottom value; the internal path overflows
    // and must saturate quietly, only the final stage reporting a clip
    task automatic test_register_extremes();
        write_all(COEF_MAX);
        send_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX));
        send_pair(SAMPLE_BITS'(SAMPLE_MIN), 24'h000001);
        send_pair(24'h000100, SAMPLE_BITS'(SAMPLE_MIN));
        wait_idle();
        write_all(COEF_MIN);
        send_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MIN));
        send_pair('1, 24'h7FFF00);
        send_pair('0, '0);
        wait_idle();
    endtask

    // Low shelf with half gain 2.0 and no allpass: full-scale samples must clip
    task automatic test_output_clipping();
        write_all(0);
        write_reg(REG_LOW_HALF_GAIN, 2 * int'(UNITY));
        send_pair(SAMPLE_BITS'(SAMPLE_MAX), 24'h000010);
        send_pair(24'h000010, SAMPLE_BITS'(SAMPLE_MIN));
        send_pair(24'h600000, 24'hA00000);
        send_pair(24'h000001, 24'hFFFFFF);
        wait_idle();
    endtask

    // A write outside the map must leave every register as it was
    task automatic test_unknown_index();
        write_reg(REG_UNUSED, COEF_MAX);
        send_pair(24'h123456, 24'hEDCBA9);
        send_pair(SAMPLE_BITS'(SAMPLE_MAX), 24'h000000);
        send_pair(24'h400000, 24'hC00000);
        wait_idle();
    endtask

    task automatic run_random_phase(input bank_kind_t kind, input int count, input bit calm,
                                    input bit pause_midway);
        program_bank(kind);
        steady = calm;
        for (int i = 0; i < count; i++)
        begin
            // sender holds off until the pipe is empty, then resumes
            if (pause_midway && i == count / 2)
                wait_idle();
            send_pair(random_sample(), random_sample());
        end
        wait_idle();
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(BANK_MILD,   90, 1'b1, 1'b0);
        run_random_phase(BANK_MILD,   90, 1'b0, 1'b0);
        run_random_phase(BANK_STRONG, 90, 1'b0, 1'b0);
        run_random_phase(BANK_WIDE,   90, 1'b0, 1'b0);
        run_random_phase(BANK_MILD,  100, 1'b0, 1'b1);
        // finish at both corners of the register range
        write_all(COEF_MIN);
        steady = 1'b0;
        for (int i = 0; i < 45; i++)
            send_pair(random_sample(), random_sample());
        wait_idle();
        write_all(COEF_MAX);
        for (int i = 0; i < 45; i++)
            send_pair(random_sample(), random_sample());
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall and result checking
    // ------------------------------------------------------------------

    // out_stall runs in stretches; a third of them stalled, some of those long
    initial
    begin : stall_drive
        int run;
        bit level;
        run   = 0;
        level = 1'b0;
        forever
        begin
            @(posedge clk);
            if (steady)
            begin
                level = 1'b0;
                run   = 0;
            end
            else if (run == 0)
            begin
                level = ($urandom_range(0, 2) == 0);
                run   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70)
                                                    : $urandom_range(1, 4);
            end
            else
                run--;
            out_stall <= level;
        end
    end

    task automatic report_mismatch(input string field, input longint want, input longint got);
        errors++;
        if (reported < 100)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        reported++;
    endtask

    // A beat leaves the block at an edge with out_valid high and out_stall low
    always @(posedge clk)
    begin : result_monitor
        out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, got %h", $time,
                         out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.left_result !== want.left_result)
                    report_mismatch("left_result", $signed(want.left_result),
                                    $signed(out_data.left_result));
                if (out_data.right_result !== want.right_result)
                    report_mismatch("right_result", $signed(want.right_result),
                                    $signed(out_data.right_result));
                if (out_data.clipped !== want.clipped)
                    report_mismatch("clipped", want.clipped, out_data.clipped);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin : main_sequence
        for (int i = 0; i < NUM_REGS; i++)
            coef_bank[i] = 0;
        for (int ch = 0; ch < 2; ch++)
        begin
            low_state[ch]  = 0;
            high_state[ch] = 0;
            peak_one[ch]   = 0;
            peak_two[ch]   = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_flat_after_reset();
        test_register_extremes();
        test_output_clipping();
        test_unknown_index();
        test_random_traffic();

        // leftover expectations are caught here
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, several times the slowest plausible run
    initial
    begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
